FILE: rtl/core/cbba_pkg.sv
// ----------------------------------------------------------------------------
// cbba_pkg
// Shared types and constants for the contiguous block bitmap allocator.
// ----------------------------------------------------------------------------
package cbba_pkg;

  localparam int REQ_W  = 16;             // request_bytes
  localparam int SB_W   = 8;              // start_block
  localparam int BS_W   = 12;             // block_bytes
  localparam int Q_W    = 17;             // dividend / quotient
  localparam int P_W    = Q_W + BS_W;     // multiplier product
  localparam int IDX_W  = 5;              // first granted block
  localparam int GR_W   = 17;             // granted_bytes
  localparam int STAT_W = 2;

  localparam logic [BS_W-1:0] BS_RESET = 12'd512;
  localparam logic [BS_W-1:0] BS_MIN   = 12'd4;

  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [STAT_W-1:0] ST_INVALID = 2'd2;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [1:0] {
    MUL_QUOT,
    MUL_START,
    MUL_POOL
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     div_step;
    logic     scan_step;
    mul_sel_t mul_sel;
    logic     mul_en;
    logic     sum_en;
    logic     check_en;
    logic     out_load;
  } cbba_cmd_t;

  typedef struct packed {
    logic div_last;
    logic scan_last;
    logic mode;
  } cbba_stat_t;

endpackage

FILE: rtl/core/cbba_dp.sv
// ----------------------------------------------------------------------------
// cbba_dp
// Datapath: block size register, serial divider, usage bitmap scanner,
// shared multiplier, bounds check and result registers.
// ----------------------------------------------------------------------------
module cbba_dp #(
  parameter int POOL_BLOCKS  = 32,
  parameter int HEADER_BYTES = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [cbba_pkg::BS_W-1:0]     cfg_wdata,
  input  logic                          req_mode,
  input  logic [cbba_pkg::REQ_W-1:0]    req_bytes,
  input  logic [cbba_pkg::SB_W-1:0]     req_start,
  input  cbba_pkg::cbba_cmd_t           cmd,
  output cbba_pkg::cbba_stat_t          stat,
  output logic [cbba_pkg::STAT_W-1:0]   res_status,
  output logic [cbba_pkg::IDX_W-1:0]    res_index,
  output logic [cbba_pkg::GR_W-1:0]     res_granted
);
  import cbba_pkg::*;

  localparam int IW    = (POOL_BLOCKS > 1) ? $clog2(POOL_BLOCKS) : 1;
  localparam int RW    = $clog2(POOL_BLOCKS + 1);
  localparam int SUM_W = P_W + 1;

  logic [BS_W-1:0]        bs_cfg_r;
  logic [BS_W-1:0]        bs_eff;
  logic [POOL_BLOCKS-1:0] usage_r, usage_nxt;

  logic                   mode_r;
  logic [REQ_W-1:0]       req_r;
  logic [SB_W-1:0]        start_r;
  logic [Q_W-1:0]         dvd_r;
  logic [BS_W-1:0]        rem_r;
  logic [4:0]             div_cnt_r;
  logic [BS_W:0]          trial;
  logic                   qbit;

  logic [IW-1:0]          idx_r;
  logic [RW-1:0]          run_r, run_nxt;
  logic [IW-1:0]          rs_r, rs_nxt;
  logic [POOL_BLOCKS-1:0] mask_r, mask_nxt, onehot;
  logic                   found_r, found_nxt;
  logic                   free_ok_r;
  logic [SB_W-1:0]        idx8;
  logic                   in_rng;

  logic [Q_W-1:0]         mul_a;
  logic [P_W-1:0]         prod_r;
  logic [SUM_W-1:0]       sum_r;
  logic [IW+IDX_W-1:0]    rs_ext;
  logic [P_W-1:0]         gr_full;

  assign bs_eff = (bs_cfg_r < BS_MIN) ? BS_MIN : bs_cfg_r;

  // restoring divide step
  assign trial = {rem_r, dvd_r[Q_W-1]} - {1'b0, bs_eff};
  assign qbit  = ~trial[BS_W] | rem_r[BS_W-1];

  // bitmap scan
  assign onehot = POOL_BLOCKS'(1) << idx_r;
  assign idx8   = SB_W'(idx_r);
  assign in_rng = (idx8 >= start_r) && (Q_W'(SB_W'(idx8 - start_r)) < dvd_r);

  always_comb begin
    usage_nxt = usage_r;
    run_nxt   = run_r;
    rs_nxt    = rs_r;
    mask_nxt  = mask_r;
    found_nxt = found_r;
    if (mode_r == MODE_ALLOC) begin
      if (!found_r) begin
        if (usage_r[idx_r]) begin
          run_nxt  = '0;
          mask_nxt = '0;
        end else begin
          run_nxt  = run_r + RW'(1);
          mask_nxt = mask_r | onehot;
          if (run_r == '0) begin
            rs_nxt = idx_r;
          end
          if (Q_W'(run_r) + Q_W'(1) == dvd_r) begin
            found_nxt = 1'b1;
            usage_nxt = usage_r | mask_r | onehot;
          end
        end
      end
    end else if (free_ok_r && in_rng) begin
      usage_nxt = usage_r & ~onehot;
    end
  end

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_QUOT:  mul_a = dvd_r;
      MUL_START: mul_a = Q_W'(start_r);
      MUL_POOL:  mul_a = Q_W'(POOL_BLOCKS);
      default:   mul_a = dvd_r;
    endcase
  end

  assign rs_ext  = (IW+IDX_W)'(rs_r);
  assign gr_full = prod_r - P_W'(HEADER_BYTES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_cfg_r <= BS_RESET;
      usage_r  <= '0;
    end else begin
      if (cfg_we) begin
        bs_cfg_r <= cfg_wdata;
      end
      if (cmd.scan_step) begin
        usage_r <= usage_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r    <= req_mode;
      req_r     <= req_bytes;
      start_r   <= req_start;
      dvd_r     <= Q_W'(req_bytes) + Q_W'(HEADER_BYTES) + Q_W'(bs_eff) - Q_W'(1);
      rem_r     <= '0;
      div_cnt_r <= '0;
      idx_r     <= '0;
      run_r     <= '0;
      rs_r      <= '0;
      mask_r    <= '0;
      found_r   <= 1'b0;
      free_ok_r <= 1'b0;
    end else begin
      if (cmd.div_step) begin
        rem_r     <= qbit ? trial[BS_W-1:0] : {rem_r[BS_W-2:0], dvd_r[Q_W-1]};
        dvd_r     <= {dvd_r[Q_W-2:0], qbit};
        div_cnt_r <= div_cnt_r + 5'd1;
      end
      if (cmd.scan_step) begin
        idx_r   <= idx_r + IW'(1);
        run_r   <= run_nxt;
        rs_r    <= rs_nxt;
        mask_r  <= mask_nxt;
        found_r <= found_nxt;
      end
      if (cmd.check_en) begin
        free_ok_r <= (start_r < SB_W'(POOL_BLOCKS)) && !(sum_r > SUM_W'(prod_r));
      end
    end
    if (cmd.mul_en) begin
      prod_r <= P_W'(mul_a * bs_eff);
    end
    if (cmd.sum_en) begin
      sum_r <= SUM_W'(prod_r) + SUM_W'(HEADER_BYTES) + SUM_W'(req_r);
    end
    if (cmd.out_load) begin
      if (mode_r == MODE_ALLOC && found_r) begin
        res_status  <= ST_DONE;
        res_index   <= rs_ext[IDX_W-1:0];
        res_granted <= gr_full[GR_W-1:0];
      end else begin
        res_status  <= (mode_r == MODE_ALLOC) ? ST_NOSPACE :
                       (free_ok_r ? ST_DONE : ST_INVALID);
        res_index   <= '0;
        res_granted <= '0;
      end
    end
  end

  assign stat.div_last  = (div_cnt_r == 5'(Q_W - 1));
  assign stat.scan_last = (idx_r == IW'(POOL_BLOCKS - 1));
  assign stat.mode      = mode_r;

endmodule

FILE: rtl/core/cbba_ctrl.sv
// ----------------------------------------------------------------------------
// cbba_ctrl
// Sequencer: divide, then scan (allocate) or bounds check and clearing scan (free), result handoff.
// ----------------------------------------------------------------------------
module cbba_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  cbba_pkg::cbba_stat_t stat,
  output cbba_pkg::cbba_cmd_t  cmd
);
  import cbba_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_SCAN,
    S_MUL_GRANT,
    S_MUL_START,
    S_MUL_POOL,
    S_CHECK,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   resp_go;

  assign resp_go = !out_valid_r || out_tready;

  always_comb begin
    cmd           = '0;
    cmd.mul_sel   = MUL_QUOT;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = (stat.mode == MODE_ALLOC) ? S_SCAN : S_MUL_START;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_nxt = (stat.mode == MODE_ALLOC) ? S_MUL_GRANT : S_RESP;
        end
      end
      S_MUL_GRANT: begin
        cmd.mul_sel = MUL_QUOT;
        cmd.mul_en  = 1'b1;
        state_nxt   = S_RESP;
      end
      S_MUL_START: begin
        cmd.mul_sel = MUL_START;
        cmd.mul_en  = 1'b1;
        state_nxt   = S_MUL_POOL;
      end
      S_MUL_POOL: begin
        cmd.mul_sel = MUL_POOL;
        cmd.mul_en  = 1'b1;
        cmd.sum_en  = 1'b1;
        state_nxt   = S_CHECK;
      end
      S_CHECK: begin
        cmd.check_en = 1'b1;
        state_nxt    = S_SCAN;
      end
      S_RESP: begin
        if (resp_go) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

FILE: rtl/core/contiguous_block_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// contiguous_block_bitmap_allocator
// First-fit allocator over a bitmap of POOL_BLOCKS equal pool blocks.
// Allocate: load, serial divide, map scan, grant multiply, then the output word.
// Free: load, serial divide, bounds check multiplies and compare, map clear, then the output word.
// One word at a time; the divider and the bit-serial map scan set the rate.
// Sync active-low reset: map all free, block size 512, output empty.
// ----------------------------------------------------------------------------
module contiguous_block_bitmap_allocator #(
  parameter int POOL_BLOCKS  = 32,
  parameter int HEADER_BYTES = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [cbba_pkg::BS_W-1:0] cfg_wdata,      // block_bytes
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [23:0]               in_tdata,       // request_bytes, start_block
  input  logic                      in_tuser,       // mode
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [23:0]               out_tdata,      // first_block, granted_bytes, pad
  output logic [1:0]                out_tuser       // status
);
  import cbba_pkg::*;

  cbba_cmd_t             cmd;
  cbba_stat_t            stat;
  logic [STAT_W-1:0]     res_status;
  logic [IDX_W-1:0]      res_index;
  logic [GR_W-1:0]       res_granted;

  cbba_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  cbba_dp #(
    .POOL_BLOCKS  (POOL_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .req_mode    (in_tuser),
    .req_bytes   (in_tdata[15:0]),
    .req_start   (in_tdata[23:16]),
    .cmd         (cmd),
    .stat        (stat),
    .res_status  (res_status),
    .res_index   (res_index),
    .res_granted (res_granted)
  );

  assign out_tdata = {2'b00, res_granted, res_index};
  assign out_tuser = res_status;

endmodule
